FILE: rtl/core/tstiff_pkg.sv
`default_nettype none
package tstiff_pkg;

    // fixed field widths
    localparam int CoordW  = 16;
    localparam int EntryW  = 32;
    localparam int DiffW   = CoordW + 1;
    localparam int ProdW   = 2 * DiffW;
    localparam int SumW    = ProdW + 1;
    localparam int DenW    = SumW + 1;
    // quotient bits: all entry bits plus one rounding bit
    localparam int QuotW   = EntryW + 1;
    localparam int StepsPerStage = 3;
    localparam int NumDivStages  = QuotW / StepsPerStage;
    localparam int NumEntries    = 6;

    localparam logic [EntryW-1:0] EntryMax = {1'b0, {(EntryW-1){1'b1}}};
    localparam logic [EntryW-1:0] EntryMin = {1'b1, {(EntryW-1){1'b0}}};

    // row and column of each unique entry
    localparam int PairI [NumEntries] = '{0, 0, 0, 1, 1, 2};
    localparam int PairJ [NumEntries] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic signed [CoordW-1:0] ax;
        logic signed [CoordW-1:0] ay;
        logic signed [CoordW-1:0] bx;
        logic signed [CoordW-1:0] by_coord;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
    } tri_word_t;

    typedef struct packed {
        logic signed [EntryW-1:0] k_aa;
        logic signed [EntryW-1:0] k_ab;
        logic signed [EntryW-1:0] k_ac;
        logic signed [EntryW-1:0] k_bb;
        logic signed [EntryW-1:0] k_bc;
        logic signed [EntryW-1:0] k_cc;
        logic                     degenerate;
        logic                     saturated;
    } mat_word_t;

    // one entry in the divider: remainder, quotient so far, dividend bits left
    typedef struct packed {
        logic [DenW-1:0]  rem;
        logic [QuotW-1:0] quo;
        logic [QuotW-1:0] low;
        logic             neg;
        logic             sat;
    } lane_t;

    typedef struct packed {
        logic                         degen;
        logic [DenW-1:0]              den;
        lane_t [NumEntries-1:0]       lanes;
    } div_word_t;

    function automatic logic signed [DiffW-1:0] coord_diff(
        input logic signed [CoordW-1:0] a,
        input logic signed [CoordW-1:0] b
    );
        return DiffW'(a) - DiffW'(b);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tstiff_front.sv
`default_nettype none
// Edge differences, products, numerators and denominator: three stages.
module tstiff_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire tstiff_pkg::tri_word_t in_word,
    output logic                       out_valid,
    output tstiff_pkg::div_word_t      out_word
);
    localparam int IntBits = tstiff_pkg::EntryW - FRAC_BITS;
    localparam int DenW    = tstiff_pkg::DenW;
    localparam int SumW    = tstiff_pkg::SumW;
    localparam int ProdW   = tstiff_pkg::ProdW;
    localparam int DiffW   = tstiff_pkg::DiffW;
    localparam int QuotW   = tstiff_pkg::QuotW;
    localparam int NE      = tstiff_pkg::NumEntries;

    logic v1_reg, v2_reg, v3_reg;
    logic signed [DiffW-1:0] b_reg [3];
    logic signed [DiffW-1:0] c_reg [3];
    logic signed [DiffW-1:0] e_reg [4];
    logic signed [ProdW-1:0] pb_reg [NE];
    logic signed [ProdW-1:0] pc_reg [NE];
    logic signed [ProdW-1:0] pd_reg [2];
    tstiff_pkg::div_word_t   s3_reg, s3_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: edge differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg[0] <= tstiff_pkg::coord_diff(in_word.by_coord, in_word.cy);
            b_reg[1] <= tstiff_pkg::coord_diff(in_word.cy, in_word.ay);
            b_reg[2] <= tstiff_pkg::coord_diff(in_word.ay, in_word.by_coord);
            c_reg[0] <= tstiff_pkg::coord_diff(in_word.cx, in_word.bx);
            c_reg[1] <= tstiff_pkg::coord_diff(in_word.ax, in_word.cx);
            c_reg[2] <= tstiff_pkg::coord_diff(in_word.bx, in_word.ax);
            e_reg[0] <= tstiff_pkg::coord_diff(in_word.bx, in_word.ax);
            e_reg[1] <= tstiff_pkg::coord_diff(in_word.cy, in_word.ay);
            e_reg[2] <= tstiff_pkg::coord_diff(in_word.cx, in_word.ax);
            e_reg[3] <= tstiff_pkg::coord_diff(in_word.by_coord, in_word.ay);
        end
    end

    // stage 2: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
            begin
                pb_reg[k] <= ProdW'(b_reg[tstiff_pkg::PairI[k]])
                           * ProdW'(b_reg[tstiff_pkg::PairJ[k]]);
                pc_reg[k] <= ProdW'(c_reg[tstiff_pkg::PairI[k]])
                           * ProdW'(c_reg[tstiff_pkg::PairJ[k]]);
            end
            pd_reg[0] <= ProdW'(e_reg[0]) * ProdW'(e_reg[1]);
            pd_reg[1] <= ProdW'(e_reg[2]) * ProdW'(e_reg[3]);
        end
    end

    // stage 3: numerators, doubled |D|, range check, divider seed
    always_comb
    begin
        logic signed [SumW-1:0] d;
        logic signed [SumW-1:0] n;
        logic [SumW-1:0]        absd;
        logic [SumW-1:0]        mag;
        logic [DenW-1:0]        den;
        logic [DenW+tstiff_pkg::EntryW-1:0] den_big;
        logic [SumW+QuotW-1:0]  ext;
        d    = SumW'(pd_reg[0]) - SumW'(pd_reg[1]);
        absd = d[SumW-1] ? SumW'(-d) : SumW'(d);
        den  = {absd[SumW-2:0], 2'b00} >> 1;
        s3_next.degen = (d == '0);
        s3_next.den   = den;
        den_big = {{tstiff_pkg::EntryW{1'b0}}, den} << IntBits;
        for (int k = 0; k < NE; k++)
        begin
            n   = SumW'(pb_reg[k]) + SumW'(pc_reg[k]);
            mag = n[SumW-1] ? SumW'(-n) : SumW'(n);
            ext = {{QuotW{1'b0}}, mag} << (FRAC_BITS + 1);
            s3_next.lanes[k].neg = n[SumW-1];
            s3_next.lanes[k].sat = ({{(DenW+tstiff_pkg::EntryW-SumW){1'b0}}, mag}
                                    >= den_big);
            s3_next.lanes[k].rem = DenW'(mag >> IntBits);
            s3_next.lanes[k].quo = '0;
            s3_next.lanes[k].low = ext[QuotW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_word  = s3_reg;

endmodule
`default_nettype wire

FILE: rtl/core/tstiff_div_stage.sv
`default_nettype none
// StepsPerStage restoring-division steps for all entries, then a register.
module tstiff_div_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire tstiff_pkg::div_word_t in_word,
    output logic                       out_valid,
    output tstiff_pkg::div_word_t      out_word
);
    localparam int DenW  = tstiff_pkg::DenW;
    localparam int QuotW = tstiff_pkg::QuotW;

    logic                  valid_reg;
    tstiff_pkg::div_word_t word_reg, word_next;

    // shift in one dividend bit per step, subtract when it fits
    always_comb
    begin
        logic [DenW:0] trial;
        word_next = in_word;
        for (int k = 0; k < tstiff_pkg::NumEntries; k++)
        begin
            for (int s = 0; s < tstiff_pkg::StepsPerStage; s++)
            begin
                trial = {word_next.lanes[k].rem, word_next.lanes[k].low[QuotW-1]};
                word_next.lanes[k].low = {word_next.lanes[k].low[QuotW-2:0], 1'b0};
                if (trial >= {1'b0, in_word.den})
                begin
                    trial = trial - {1'b0, in_word.den};
                    word_next.lanes[k].quo = {word_next.lanes[k].quo[QuotW-2:0], 1'b1};
                end
                else
                begin
                    word_next.lanes[k].quo = {word_next.lanes[k].quo[QuotW-2:0], 1'b0};
                end
                word_next.lanes[k].rem = trial[DenW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

FILE: rtl/core/tstiff_finish.sv
`default_nettype none
// Round half away from zero, apply sign, saturate; output register.
module tstiff_finish (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire tstiff_pkg::div_word_t in_word,
    output logic                       out_valid,
    output tstiff_pkg::mat_word_t      out_word
);
    localparam int QuotW  = tstiff_pkg::QuotW;
    localparam int EntryW = tstiff_pkg::EntryW;
    localparam int NE     = tstiff_pkg::NumEntries;

    logic                  valid_reg;
    tstiff_pkg::mat_word_t word_reg, word_next;

    always_comb
    begin
        logic [QuotW:0]     qp;
        logic [QuotW-1:0]   m;
        logic [EntryW-1:0]  ent [NE];
        logic               any_sat;
        any_sat = 1'b0;
        for (int k = 0; k < NE; k++)
        begin
            qp = {1'b0, in_word.lanes[k].quo} + (QuotW+1)'(1);
            m  = qp[QuotW:1];
            if (in_word.lanes[k].neg)
            begin
                if (in_word.lanes[k].sat || (m > QuotW'(tstiff_pkg::EntryMin)))
                begin
                    ent[k]  = tstiff_pkg::EntryMin;
                    any_sat = 1'b1;
                end
                else
                begin
                    ent[k] = EntryW'(-m);
                end
            end
            else
            begin
                if (in_word.lanes[k].sat || (m > QuotW'(tstiff_pkg::EntryMax)))
                begin
                    ent[k]  = tstiff_pkg::EntryMax;
                    any_sat = 1'b1;
                end
                else
                begin
                    ent[k] = m[EntryW-1:0];
                end
            end
        end
        if (in_word.degen)
        begin
            word_next = '0;
            word_next.degenerate = 1'b1;
        end
        else
        begin
            word_next.k_aa = ent[0];
            word_next.k_ab = ent[1];
            word_next.k_ac = ent[2];
            word_next.k_bb = ent[3];
            word_next.k_bc = ent[4];
            word_next.k_cc = ent[5];
            word_next.degenerate = 1'b0;
            word_next.saturated  = any_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

FILE: rtl/core/p1_triangle_stiffness.sv
// P1 triangle stiffness: one triangle word in, one matrix word out.
// Input channel tri_valid / tri_stall / tri_word carries the three vertices;
// a word is taken at a clock edge with tri_valid high and tri_stall low.
// Output channel mat_valid / mat_stall / mat_word carries the six unique
// entries of the symmetric 3x3 matrix in signed fixed point with FRAC_BITS
// fraction bits, plus the degenerate and saturated flags.
// From acceptance to mat_valid a word passes three front stages
// (differences, 17x17 products, sums and range check), eleven divider
// stages of three restoring steps each for all six entries side by side,
// and one rounding and saturation stage with the output register.
// Throughput is one triangle per cycle, except while mat_stall holds the pipeline.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// When mat_stall is high while a word waits, the whole pipeline holds and
// tri_stall goes high in that cycle; nothing is dropped or repeated.
// Bubbles stay in place while stalled and move on once the stall clears.
`default_nettype none
module p1_triangle_stiffness #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tri_valid,
    output logic                       tri_stall,
    input  wire tstiff_pkg::tri_word_t tri_word,
    output logic                       mat_valid,
    input  wire logic                  mat_stall,
    output tstiff_pkg::mat_word_t      mat_word
);
    localparam int NStages = tstiff_pkg::NumDivStages;

    logic                  en;
    logic                  sv [NStages+1];
    tstiff_pkg::div_word_t sw [NStages+1];

    // one enable for the whole pipe
    assign en        = !(mat_valid && mat_stall);
    assign tri_stall = !en;

    tstiff_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tri_valid),
        .in_word   (tri_word),
        .out_valid (sv[0]),
        .out_word  (sw[0])
    );

    for (genvar g = 0; g < NStages; g++)
    begin : g_div
        tstiff_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sv[g]),
            .in_word   (sw[g]),
            .out_valid (sv[g+1]),
            .out_word  (sw[g+1])
        );
    end

    tstiff_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sv[NStages]),
        .in_word   (sw[NStages]),
        .out_valid (mat_valid),
        .out_word  (mat_word)
    );

    // zero area gives all zero entries and no clip flag
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat_word.degenerate |->
            mat_word.k_aa == '0 && mat_word.k_ab == '0 && mat_word.k_ac == '0 &&
            mat_word.k_bb == '0 && mat_word.k_bc == '0 && mat_word.k_cc == '0 &&
            !mat_word.saturated)
        else $error("degenerate word with nonzero content");

    // diagonal entries come from sums of squares
    a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid |-> !mat_word.k_aa[31] && !mat_word.k_bb[31] && !mat_word.k_cc[31])
        else $error("negative diagonal entry");

    // a stall freezes the last divider stage
    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sv[NStages]) && $stable(sw[NStages]))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

FILE: sim/tstiff_checker.sv
`default_nettype none
module tstiff_checker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tri_valid,
    input  wire logic                  tri_stall,
    input  wire tstiff_pkg::tri_word_t tri_word,
    input  wire logic                  mat_valid,
    input  wire logic                  mat_stall,
    input  wire tstiff_pkg::mat_word_t mat_word,
    output int                         errors,
    output int                         pending
);
    localparam int Frac = 16;

    tstiff_pkg::mat_word_t matrix_queue[$];

    assign pending = matrix_queue.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // rounded quotient num/den in fixed point, saturated to 32 bits
    function automatic logic [31:0] entry_quot(input longint num, input longint den,
                                               inout logic sat);
        logic            neg;
        logic [63:0]     mag;
        logic [63:0]     q0;
        logic [63:0]     rem;
        logic [63:0]     m;
        neg = num < 0;
        mag = neg ? -num : num;
        q0 = mag / den;
        rem = mag % den;
        if (q0 >= (64'd1 << (32 - Frac)))
        begin
            sat = 1'b1;
            return neg ? tstiff_pkg::EntryMin : tstiff_pkg::EntryMax;
        end
        m = q0 << Frac;
        for (int i = Frac - 1; i >= 0; i--)
        begin
            rem = rem << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                m[i] = 1'b1;
            end
        end
        rem = rem << 1;
        if (rem >= den)
            m = m + 1;
        if (neg)
        begin
            if (m > 64'h8000_0000)
            begin
                sat = 1'b1;
                return tstiff_pkg::EntryMin;
            end
            return 32'(-m);
        end
        if (m > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return tstiff_pkg::EntryMax;
        end
        return m[31:0];
    endfunction

    function automatic tstiff_pkg::mat_word_t stiffness(input tstiff_pkg::tri_word_t t);
        tstiff_pkg::mat_word_t r;
        longint      gb[3];
        longint      gc[3];
        longint      area2;
        longint      den;
        logic [31:0] k[6];
        logic        sat;
        int          n;
        gb[0] = longint'(t.by_coord) - t.cy;  gc[0] = longint'(t.cx) - t.bx;
        gb[1] = longint'(t.cy) - t.ay;        gc[1] = longint'(t.ax) - t.cx;
        gb[2] = longint'(t.ay) - t.by_coord;  gc[2] = longint'(t.bx) - t.ax;
        area2 = (longint'(t.bx) - t.ax) * (longint'(t.cy) - t.ay)
              - (longint'(t.cx) - t.ax) * (longint'(t.by_coord) - t.ay);
        r = '0;
        if (area2 == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        den = 2 * (area2 < 0 ? -area2 : area2);
        sat = 1'b0;
        n = 0;
        for (int i = 0; i < 3; i++)
            for (int j = i; j < 3; j++)
            begin
                k[n] = entry_quot(gb[i] * gb[j] + gc[i] * gc[j], den, sat);
                n++;
            end
        r.k_aa = k[0]; r.k_ab = k[1]; r.k_ac = k[2];
        r.k_bb = k[3]; r.k_bc = k[4]; r.k_cc = k[5];
        r.saturated = sat;
        return r;
    endfunction

    initial errors = 0;

    // predict on input words, compare on output words
    always @(posedge clk)
    begin
        tstiff_pkg::mat_word_t want;
        if (rst_n)
        begin
            if (tri_valid && !tri_stall)
                matrix_queue.push_back(stiffness(tri_word));
            if (mat_valid && !mat_stall)
            begin
                if (matrix_queue.size() == 0)
                    report("unexpected word", mat_word[31:0], 32'h0);
                else
                begin
                    want = matrix_queue.pop_front();
                    if (mat_word.k_aa !== want.k_aa) report("k_aa", mat_word.k_aa, want.k_aa);
                    if (mat_word.k_ab !== want.k_ab) report("k_ab", mat_word.k_ab, want.k_ab);
                    if (mat_word.k_ac !== want.k_ac) report("k_ac", mat_word.k_ac, want.k_ac);
                    if (mat_word.k_bb !== want.k_bb) report("k_bb", mat_word.k_bb, want.k_bb);
                    if (mat_word.k_bc !== want.k_bc) report("k_bc", mat_word.k_bc, want.k_bc);
                    if (mat_word.k_cc !== want.k_cc) report("k_cc", mat_word.k_cc, want.k_cc);
                    if (mat_word.degenerate !== want.degenerate)
                        report("degenerate", 32'(mat_word.degenerate), 32'(want.degenerate));
                    if (mat_word.saturated !== want.saturated)
                        report("saturated", 32'(mat_word.saturated), 32'(want.saturated));
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
    localparam int Latency  = 15;
    localparam int IdleMax  = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  tri_valid = 1'b0;
    logic                  tri_stall;
    tstiff_pkg::tri_word_t tri_word = '0;
    logic                  mat_valid;
    logic                  mat_stall = 1'b0;
    tstiff_pkg::mat_word_t mat_word;
    int                    errors;
    int                    pending;
    int                    idle_cycles = 0;

    always #10 clk = ~clk;

    p1_triangle_stiffness dut (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_word(tri_word),
        .mat_valid(mat_valid), .mat_stall(mat_stall), .mat_word(mat_word)
    );

    tstiff_checker chk (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_word(tri_word),
        .mat_valid(mat_valid), .mat_stall(mat_stall), .mat_word(mat_word),
        .errors(errors), .pending(pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($signed($urandom_range(0, 40)) - 20);
            1: return 16'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(0, 3))
                                           : 16'(16'h8000 + $urandom_range(0, 3));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic tstiff_pkg::tri_word_t rand_tri();
        tstiff_pkg::tri_word_t t;
        t.ax = rand_coord(); t.ay = rand_coord();
        t.bx = rand_coord(); t.by_coord = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord();
        // sometimes collinear: C on line AB
        if ($urandom_range(0, 15) == 0)
        begin
            t.cx = 16'(t.ax + 2 * (t.bx - t.ax));
            t.cy = 16'(t.ay + 2 * (t.by_coord - t.ay));
        end
        // sometimes a thin sliver, which can drive entries to saturation
        else if ($urandom_range(0, 15) == 0)
        begin
            t.cx = 16'(t.bx + 1);
            t.cy = t.by_coord;
            t.ax = t.bx + 16'($urandom_range(0, 1));
        end
        return t;
    endfunction

    task automatic send(input tstiff_pkg::tri_word_t t);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            tri_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        tri_word  <= t;
        tri_valid <= 1'b1;
        @(posedge clk);
        while (tri_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic tstiff_pkg::tri_word_t mk(input int x1, y1, x2, y2, x3, y3);
        tstiff_pkg::tri_word_t t;
        t.ax = 16'(x1); t.ay = 16'(y1); t.bx = 16'(x2);
        t.by_coord = 16'(y2); t.cx = 16'(x3); t.cy = 16'(y3);
        return t;
    endfunction

    // receiver stall pattern
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g > 0)
            begin
                mat_stall <= 1'b1;
                repeat (g) @(negedge clk);
            end
            mat_stall <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((tri_valid && !tri_stall) || (mat_valid && !mat_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleMax)
        begin
            $display("p1_triangle_stiffness: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: unit triangle both orientations, extremes, degenerate, slivers
        send(mk(0, 0, 1, 0, 0, 1));
        send(mk(0, 0, 0, 1, 1, 0));
        send(mk(0, 0, 0, 0, 0, 0));
        send(mk(1, 1, 2, 2, 3, 3));
        send(mk(-32768, -32768, 32767, -32768, -32768, 32767));
        send(mk(32767, 32767, -32768, 32767, 32767, -32768));
        send(mk(-32768, -32768, 32767, 32767, -32768, 32767));
        send(mk(0, 0, 32767, 0, 32767, 1));
        send(mk(-32768, 0, 32767, 0, 0, 1));
        send(mk(0, 0, 2, 0, 1, 1));
        send(mk(0, 0, 3, 0, 0, 3));
        send(mk(0, 0, 1, 0, 0, 3));
        send(mk(5, -7, 5, -7, 100, 3));
        send(mk(-1, -1, -1, -1, -1, -1));
        send(mk(0, 0, 1, 0, 2, 1));
        send(mk(0, 0, 3, 1, 1, 2));
        // hold off until the pipeline drains
        tri_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        for (int n = 0; n < 1750; n++)
        begin
            send(rand_tri());
            if (n == 900)
            begin
                tri_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
        end
        tri_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (Latency + 10) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("p1_triangle_stiffness: match");
        else
            $display("p1_triangle_stiffness: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/tstiff_pkg.sv
rtl/core/tstiff_front.sv
rtl/core/tstiff_div_stage.sv
rtl/core/tstiff_finish.sv
rtl/core/p1_triangle_stiffness.sv
sim/tstiff_checker.sv
sim/tb.sv
